FILE: design/b64b32dec_pkg.sv
package b64b32dec_pkg;

  // Depth of the job queue between front and back.
  localparam int unsigned JobQDepth = 4;

  localparam int unsigned GroupW = 40;  // bits held for one group
  localparam int unsigned CountW = 3;   // 1..5 bytes per job

  typedef enum logic [1:0] {
    ST_DATA    = 2'd0,
    ST_BADCHAR = 2'd1,
    ST_END_ERR = 2'd2,
    ST_END_OK  = 2'd3
  } status_e;

  typedef enum logic {
    CMD_CHAR = 1'b0,
    CMD_END  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_char;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
  } out_beat_t;

  // One queued job: up to five bytes, left aligned, and the beat status.
  typedef struct packed {
    logic [GroupW-1:0] data;
    logic [CountW-1:0] nbytes;
    status_e           status;
  } job_t;

endpackage

FILE: design/base64_base32_decoder_top.sv
// Base64 / base32 text decoder. One character beat enters per cycle while
// the job queue has room; skipped whitespace and digits or pads that do not
// finish a group leave no result. A finished group gives 1..3 (base64) or
// 1..5 (base32) byte beats, MSB first, drained at one beat per cycle while
// out_ready_i is high; an invalid character gives one status beat and blocks
// output until the end-of-stream beat, which always gives one status beat and
// clears the group and the error flag. An item's job is queued, then loaded
// into the output register. Input rate is bounded by the job queue (QDepth
// jobs) draining through the single output register: sustained one character
// per cycle while out_ready_i is high, since a group of 4 or 8 characters
// yields at most 3 or 5 bytes. The user must write mode_q through cfg_we_i /
// cfg_wdata_i only while idle; the block itself does not enforce this.
module base64_base32_decoder_top import b64b32dec_pkg::*; #(
  parameter int unsigned QDepth = JobQDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  logic mode_q;
  logic push, q_full, pop, head_valid;
  job_t push_job, head_job;

  // Mode register: 0 base64, 1 base32.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Front: classify characters, build groups, post jobs.
  b64b32dec_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_b32_i (mode_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .push_o     (push),
    .push_job_o (push_job),
    .q_full_i   (q_full)
  );

  // Job queue decouples character intake from byte output.
  b64b32dec_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  // Back: split each job into output beats.
  b64b32dec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_beat_o   (out_beat_o)
  );

endmodule

FILE: design/b64b32dec_front.sv
module b64b32dec_front import b64b32dec_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     mode_b32_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_beat_t in_beat_i,
  output logic     push_o,
  output job_t     push_job_o,
  input  logic     q_full_i
);

  logic [GroupW-1:0] gb_q, gb_d;
  logic [3:0]        digits_q, digits_d;
  logic [2:0]        real_q, real_d;
  logic              err_q, err_d;

  logic [7:0] ch;
  logic [5:0] val;
  logic       is_pad, is_bad, is_skip;
  logic [GroupW-1:0] gb_n;
  logic [3:0]        digits_n;
  logic [2:0]        real_n;
  logic [2:0]        width;
  logic [3:0]        gsize;
  logic [5:0]        prod;
  logic [CountW-1:0] cnt, max_b;
  logic              accept;

  assign ch         = in_beat_i.in_char;
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign width      = mode_b32_i ? 3'd5 : 3'd6;
  assign gsize      = mode_b32_i ? 4'd8 : 4'd4;
  assign max_b      = mode_b32_i ? CountW'(5) : CountW'(3);

  // Character classification.
  always_comb begin
    val     = '0;
    is_pad  = 1'b0;
    is_bad  = 1'b0;
    is_skip = 1'b0;
    if (ch == 8'h20 || ch == 8'h09 || ch == 8'h0D || ch == 8'h0A) begin
      is_skip = 1'b1;
    end else if (ch == 8'h3D) begin
      is_pad = 1'b1;
    end else if (ch inside {[8'h41:8'h5A]}) begin
      val = 6'(ch - 8'h41);
    end else if (mode_b32_i) begin
      if (ch inside {[8'h61:8'h7A]}) begin
        val = 6'(ch - 8'h61);
      end else if (ch inside {[8'h32:8'h37]}) begin
        val = 6'(ch - 8'h32 + 8'd26);
      end else begin
        is_bad = 1'b1;
      end
    end else begin
      if (ch inside {[8'h61:8'h7A]}) begin
        val = 6'(ch - 8'h61 + 8'd26);
      end else if (ch inside {[8'h30:8'h39]}) begin
        val = 6'(ch - 8'h30 + 8'd52);
      end else if (ch == 8'h2B || ch == 8'h2D) begin
        val = 6'd62;
      end else if (ch == 8'h2F || ch == 8'h5F) begin
        val = 6'd63;
      end else begin
        is_bad = 1'b1;
      end
    end
  end

  // Group update for a digit.
  always_comb begin
    real_n = real_q;
    if (!is_pad && digits_q >= 4'd2 && real_q < 3'd7) begin
      real_n = real_q + 3'd1;
    end
    if (mode_b32_i) begin
      gb_n = {gb_q[GroupW-6:0], val[4:0]};
    end else begin
      gb_n = {gb_q[GroupW-7:0], val};
    end
    digits_n = digits_q + 4'd1;
    // Up to 6 * 9 = 54, so 6 bits throughout.
    prod = 6'(width) * (6'd2 + 6'(real_n));
    cnt  = CountW'(prod >> 3);
    if (cnt > max_b) begin
      cnt = max_b;
    end
  end

  always_comb begin
    gb_d       = gb_q;
    digits_d   = digits_q;
    real_d     = real_q;
    err_d      = err_q;
    push_o     = 1'b0;
    push_job_o = '{data: '0, nbytes: CountW'(1), status: ST_DATA};
    if (accept) begin
      if (in_beat_i.cmd == CMD_END) begin
        push_o            = 1'b1;
        push_job_o.status = (digits_q != 4'd0 || err_q) ? ST_END_ERR : ST_END_OK;
        gb_d     = '0;
        digits_d = '0;
        real_d   = '0;
        err_d    = 1'b0;
      end else if (is_skip || err_q) begin
        // nothing
      end else if (is_bad) begin
        push_o            = 1'b1;
        push_job_o.status = ST_BADCHAR;
        err_d             = 1'b1;
      end else if (digits_n >= gsize) begin
        push_o            = 1'b1;
        push_job_o.nbytes = cnt;
        push_job_o.data   = mode_b32_i ? gb_n : {gb_n[23:0], 16'h0000};
        gb_d     = '0;
        digits_d = '0;
        real_d   = '0;
      end else begin
        gb_d     = gb_n;
        digits_d = digits_n;
        real_d   = real_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gb_q     <= '0;
      digits_q <= '0;
      real_q   <= '0;
      err_q    <= 1'b0;
    end else begin
      gb_q     <= gb_d;
      digits_q <= digits_d;
      real_q   <= real_d;
      err_q    <= err_d;
    end
  end

endmodule

FILE: design/b64b32dec_queue.sv
module b64b32dec_queue import b64b32dec_pkg::*; #(
  parameter int unsigned Depth = JobQDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output job_t head_job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_job_o   = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: design/b64b32dec_back.sv
module b64b32dec_back import b64b32dec_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  job_t      head_job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  logic [CountW-1:0] idx_q, idx_d;
  logic              ov_q, ov_d;
  out_beat_t         ob_q;
  logic              load, is_last;
  logic [GroupW-1:0] shifted;

  assign load    = head_valid_i && (!ov_q || out_ready_i);
  assign is_last = (idx_q + CountW'(1)) == head_job_i.nbytes;
  assign shifted = head_job_i.data << {idx_q, 3'b000};
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d = idx_q;
    ov_d  = ov_q;
    if (out_ready_i) begin
      ov_d = 1'b0;
    end
    if (load) begin
      ov_d  = 1'b1;
      idx_d = is_last ? '0 : idx_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ob_q.out_byte <= shifted[GroupW-1 -: 8];
      ob_q.status   <= head_job_i.status;
      ob_q.last     <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      ov_q  <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_beat_o  = ob_q;

endmodule
